FILE: hdl/stable_priority_queue_top_defines.svh
// Assertion macros shared by the stable priority queue RTL.
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside of reset.
`define SPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SPQ_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hdl/spq_pkg.sv
// Types and constants shared by the stable priority queue modules.
package spq_pkg;

   // Default sizing of the queue
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 16;

   // Field widths of the stream payloads
   localparam int TAG_W    = 16;
   localparam int PRIO_W   = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;
   localparam int REQ_W    = TAG_W + PRIO_W;
   localparam int RSP_W    = 24;

   // Operation carried with each request transaction
   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // Result status of one transaction
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic push;
      logic pop;
   } cmd_type;

endpackage

FILE: hdl/stable_priority_queue_top.sv
// Stable priority queue: every request transaction yields exactly one response
// transaction. Entries sit in a row of QUEUE_DEPTH cells ordered by descending
// priority; all cells compare the new priority at once and shift in the same cycle,
// so a new request is accepted in every cycle while the response register is empty
// or being drained. A push lands behind every held entry of greater or equal
// priority (FIFO within a priority); a pop returns the head tag. A pop on an empty
// queue reports status 1 and a push on a full queue is dropped with status 2. The
// response also carries the empty flag and the entry count after the operation. No
// clearing pass is needed after reset.
`include "stable_priority_queue_top_defines.svh"

module stable_priority_queue_top #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [spq_pkg::REQ_W-1:0] req_tdata,  // [15:0] item_tag, [31:16] item_priority
   input  logic                      req_tuser,  // [0] operation
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [spq_pkg::RSP_W-1:0] rsp_tdata   // [15:0] popped_tag, [17:16] status,
                                                 // [18] queue_empty, [23:19] occupancy
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                        accept;
   spq_pkg::op_type             op;
   logic [spq_pkg::TAG_W-1:0]   req_tag;
   logic [spq_pkg::PRIO_W-1:0]  req_prio;
   logic [TAG_BITS+spq_pkg::TAG_W-1:0] tag_in_wide;
   logic [TAG_BITS-1:0]         new_tag;
   logic [TAG_BITS-1:0]         head_tag;
   logic [TAG_BITS+spq_pkg::TAG_W-1:0] tag_out_wide;
   logic                        full;
   logic                        empty;
   spq_pkg::cmd_type            cmd;

   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic [CNT_W+spq_pkg::OCC_W-1:0] occ_wide;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [spq_pkg::TAG_W-1:0]   rsp_tag_ff;
   logic [spq_pkg::TAG_W-1:0]   rsp_tag_in;
   spq_pkg::status_type         rsp_status_ff;
   spq_pkg::status_type         rsp_status_in;
   logic                        rsp_empty_ff;
   logic                        rsp_empty_in;
   logic [spq_pkg::OCC_W-1:0]   rsp_occ_ff;
   logic [spq_pkg::OCC_W-1:0]   rsp_occ_in;

   // Unpack the request transaction
   assign op       = spq_pkg::op_type'(req_tuser);
   assign req_tag  = req_tdata[spq_pkg::TAG_W-1:0];
   assign req_prio = req_tdata[spq_pkg::REQ_W-1:spq_pkg::TAG_W];

   // Fit the tag to the stored width
   assign tag_in_wide = {{TAG_BITS{1'b0}}, req_tag};
   assign new_tag     = tag_in_wide[TAG_BITS-1:0];

   // Accept while the response register is free or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;

   // Command the cell row only for operations that change the queue
   always_comb begin
      cmd.push = accept && (op == spq_pkg::OP_PUSH) && !full;
      cmd.pop  = accept && (op == spq_pkg::OP_POP) && !empty;
   end

   spq_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_chain (
      .clock    (clock),
      .cmd      (cmd),
      .new_tag  (new_tag),
      .new_prio (req_prio),
      .count    (count_ff),
      .head_tag (head_tag)
   );

   // Advance the entry count
   always_comb begin
      priority if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // Build the response of the accepted transaction
   assign tag_out_wide = {{spq_pkg::TAG_W{1'b0}}, head_tag};
   assign occ_wide     = {{spq_pkg::OCC_W{1'b0}}, count_in};

   always_comb begin
      rsp_tag_in    = '0;
      rsp_status_in = spq_pkg::ST_OK;
      unique case (op)
         spq_pkg::OP_PUSH: begin
            rsp_status_in = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
         end
         spq_pkg::OP_POP: begin
            if (empty) begin
               rsp_status_in = spq_pkg::ST_EMPTY;
            end else begin
               rsp_tag_in = tag_out_wide[spq_pkg::TAG_W-1:0];
            end
         end
         default: begin
            rsp_status_in = spq_pkg::ST_OK;
         end
      endcase
      rsp_empty_in = count_in == '0;
      rsp_occ_in   = occ_wide[spq_pkg::OCC_W-1:0];
   end

   // Hold the response until the sink takes it
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tag_ff    <= rsp_tag_in;
         rsp_status_ff <= rsp_status_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_occ_ff, rsp_empty_ff, rsp_status_ff, rsp_tag_ff};

   // Count never passes the capacity of the cell row
   `SPQ_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "entry count above capacity")

   // A push that is taken grows the queue by exactly one entry
   `SPQ_ASSERT(a_push_grows, cmd.push |=> (count_ff == $past(count_ff) + CNT_W'(1)), "push did not grow count")

   // A pop on an empty queue reports empty status and a zero tag
   `SPQ_ASSERT(a_pop_empty, (accept && op == spq_pkg::OP_POP && empty) |=> (rsp_status_ff == spq_pkg::ST_EMPTY && rsp_tag_ff == '0), "bad pop on empty response")

   // Reset leaves an empty queue and no pending response
   `SPQ_ASSERT_RST(a_reset_clear, reset |=> (count_ff == '0 && !rsp_valid_ff), "reset did not clear queue")

endmodule

FILE: hdl/spq_cell.sv
// One queue slot: holds a tag and its priority and shifts with its neighbors.
module spq_cell #(
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
   input  logic                      clock,
   input  spq_pkg::cmd_type          cmd,
   input  logic [TAG_BITS-1:0]       new_tag,
   input  logic [spq_pkg::PRIO_W-1:0] new_prio,
   input  logic                      occupied,
   input  logic                      left_ge,
   input  logic [TAG_BITS-1:0]       left_tag,
   input  logic [spq_pkg::PRIO_W-1:0] left_prio,
   input  logic [TAG_BITS-1:0]       right_tag,
   input  logic [spq_pkg::PRIO_W-1:0] right_prio,
   output logic [TAG_BITS-1:0]       tag,
   output logic [spq_pkg::PRIO_W-1:0] prio,
   output logic                      ge
);

   logic [TAG_BITS-1:0]        tag_ff;
   logic [TAG_BITS-1:0]        tag_in;
   logic [spq_pkg::PRIO_W-1:0] prio_ff;
   logic [spq_pkg::PRIO_W-1:0] prio_in;

   // Entry stays ahead of a new push when it is held and ranks at least as high
   assign ge = occupied && (prio_ff >= new_prio);

   // Keep, take the new entry, take the left neighbor or take the right neighbor
   always_comb begin
      tag_in  = tag_ff;
      prio_in = prio_ff;
      priority if (cmd.push) begin
         if (ge) begin
            tag_in  = tag_ff;
            prio_in = prio_ff;
         end else if (left_ge) begin
            tag_in  = new_tag;
            prio_in = new_prio;
         end else begin
            tag_in  = left_tag;
            prio_in = left_prio;
         end
      end else if (cmd.pop) begin
         tag_in  = right_tag;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
   end

   assign tag  = tag_ff;
   assign prio = prio_ff;

endmodule

FILE: hdl/spq_chain.sv
// Row of queue cells, head at cell zero, ordered by descending priority.
module spq_chain #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF,
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                       clock,
   input  spq_pkg::cmd_type           cmd,
   input  logic [TAG_BITS-1:0]        new_tag,
   input  logic [spq_pkg::PRIO_W-1:0] new_prio,
   input  logic [CNT_W-1:0]           count,
   output logic [TAG_BITS-1:0]        head_tag
);

   logic [TAG_BITS-1:0]        cell_tag  [QUEUE_DEPTH];
   logic [spq_pkg::PRIO_W-1:0] cell_prio [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]     cell_ge;

   // Link each cell to its neighbors; the row ends feed back the new entry or the cell itself
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                       occupied;
      logic                       left_ge;
      logic [TAG_BITS-1:0]        left_tag;
      logic [spq_pkg::PRIO_W-1:0] left_prio;
      logic [TAG_BITS-1:0]        right_tag;
      logic [spq_pkg::PRIO_W-1:0] right_prio;

      assign occupied = CNT_W'(i) < count;

      if (i == 0) begin : g_head
         assign left_ge   = 1'b1;
         assign left_tag  = new_tag;
         assign left_prio = new_prio;
      end else begin : g_body
         assign left_ge   = cell_ge[i-1];
         assign left_tag  = cell_tag[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_tag  = cell_tag[i];
         assign right_prio = cell_prio[i];
      end else begin : g_inner
         assign right_tag  = cell_tag[i+1];
         assign right_prio = cell_prio[i+1];
      end

      spq_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .new_tag    (new_tag),
         .new_prio   (new_prio),
         .occupied   (occupied),
         .left_ge    (left_ge),
         .left_tag   (left_tag),
         .left_prio  (left_prio),
         .right_tag  (right_tag),
         .right_prio (right_prio),
         .tag        (cell_tag[i]),
         .prio       (cell_prio[i]),
         .ge         (cell_ge[i])
      );
   end

   assign head_tag = cell_tag[0];

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the stable priority queue: order, ties, empty and full cases.
`timescale 1ns / 1ps

module tb_top;

   localparam int DEPTH       = spq_pkg::QUEUE_DEPTH_DEF;
   localparam int TAG_W       = spq_pkg::TAG_W;
   localparam int PRIO_W      = spq_pkg::PRIO_W;
   localparam int OCC_W       = spq_pkg::OCC_W;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_LIMIT = 5000;
   localparam int CYCLE_LIMIT = 400000;

   // One response as the queue should report it
   typedef struct {
      logic [TAG_W-1:0]    popped_tag;
      spq_pkg::status_type status;
      logic                queue_empty;
      logic [OCC_W-1:0]    occupancy;
   } queue_result_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [spq_pkg::REQ_W-1:0] req_tdata  = '0;  // [15:0] item_tag, [31:16] item_priority
   logic                      req_tuser  = 1'b0; // [0] operation
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [spq_pkg::RSP_W-1:0] rsp_tdata;  // [15:0] popped_tag, [17:16] status,
                                          // [18] queue_empty, [23:19] occupancy

   // Shadow copy of the queue contents, index 0 is the head
   logic [TAG_W-1:0]  shadow_tag [DEPTH];
   logic [PRIO_W-1:0] shadow_prio[DEPTH];
   int                shadow_count = 0;

   queue_result_type pending_responses[$];
   queue_result_type want;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_left     = 0;
   bit          hold_kick     = 1'b0;
   bit          hold_seen     = 1'b0;
   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;
   int unsigned responses     = 0;
   int unsigned push_count    = 0;
   int unsigned full_drops    = 0;
   int unsigned pop_count     = 0;
   int unsigned empty_pops    = 0;
   int unsigned peak_count    = 0;
   int unsigned drain_wait;

   stable_priority_queue_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Drive rsp_tready: random stalls, or a long hold-off when a test kicks one
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen  <= hold_kick;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Advance the shadow queue by one operation and return the response it implies
   function automatic queue_result_type predict_queue_op(spq_pkg::op_type op,
                                                         logic [TAG_W-1:0] tag,
                                                         logic [PRIO_W-1:0] prio);
      queue_result_type r;
      int               slot;
      int               i;
      r.popped_tag = '0;
      r.status     = spq_pkg::ST_OK;
      if (op == spq_pkg::OP_PUSH) begin
         if (shadow_count >= DEPTH) begin
            r.status = spq_pkg::ST_FULL;
         end else begin
            slot = 0;
            while (slot < shadow_count && shadow_prio[slot] >= prio) slot++;
            for (i = shadow_count; i > slot; i--) begin
               shadow_tag[i]  = shadow_tag[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_tag[slot]  = tag;
            shadow_prio[slot] = prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = spq_pkg::ST_EMPTY;
         end else begin
            r.popped_tag = shadow_tag[0];
            for (i = 1; i < shadow_count; i++) begin
               shadow_tag[i-1]  = shadow_tag[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      r.queue_empty = (shadow_count == 0);
      r.occupancy   = OCC_W'(shadow_count);
      return r;
   endfunction

   // A handful of small priorities so that ties are common, the extremes, or half the time any value
   function automatic logic [PRIO_W-1:0] pick_priority();
      case ($urandom_range(3))
         0:       return PRIO_W'($urandom_range(3));
         1:       return $urandom_range(1) ? '1 : '0;
         default: return PRIO_W'($urandom);
      endcase
   endfunction

   // Offer one request transaction and record its expected response once accepted
   task automatic send_op(spq_pkg::op_type op, logic [TAG_W-1:0] tag,
                          logic [PRIO_W-1:0] prio);
      queue_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, tag};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_queue_op(op, tag, prio);
      pending_responses = {pending_responses, r};
      if (op == spq_pkg::OP_PUSH) begin
         push_count++;
         if (r.status == spq_pkg::ST_FULL) full_drops++;
      end else begin
         pop_count++;
         if (r.status == spq_pkg::ST_EMPTY) empty_pops++;
      end
      if (shadow_count > peak_count) peak_count = shadow_count;
   endtask

   task automatic flag_field(string name, int unsigned got, int unsigned exp_val);
      if (got != exp_val) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Response %0d: %s expected 0x%0h, got 0x%0h",
                     responses, name, exp_val, got);
      end
   endtask

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response %0d arrived with nothing expected: 0x%0h",
                        responses, rsp_tdata);
         end else begin
            want = pending_responses.pop_front();
            flag_field("popped_tag", rsp_tdata[15:0], want.popped_tag);
            flag_field("status", rsp_tdata[17:16], want.status);
            flag_field("queue_empty", rsp_tdata[18], want.queue_empty);
            flag_field("occupancy", rsp_tdata[23:19], want.occupancy);
         end
         responses++;
      end
   end

   // Pops on an empty queue, with the ignored fields at both extremes
   task automatic test_empty_pop();
      send_op(spq_pkg::OP_POP, '1, '1);
      send_op(spq_pkg::OP_POP, '0, '0);
   endtask

   // Priority order, FIFO among equal priorities, extreme tags and priorities
   task automatic test_order_and_ties();
      send_op(spq_pkg::OP_PUSH, 16'h1111, 16'h8000);
      send_op(spq_pkg::OP_PUSH, 16'h2222, 16'h8000);
      send_op(spq_pkg::OP_PUSH, 16'hFFFF, 16'hFFFF);
      send_op(spq_pkg::OP_PUSH, 16'h0000, 16'h0000);
      send_op(spq_pkg::OP_PUSH, 16'h3333, 16'h0000);
      send_op(spq_pkg::OP_PUSH, 16'h4444, 16'h8001);
      repeat (3) send_op(spq_pkg::OP_POP, 16'($urandom), 16'($urandom));
   endtask

   // Fill to capacity, push once more onto the full queue, then pop
   task automatic test_full_queue();
      while (shadow_count < DEPTH) send_op(spq_pkg::OP_PUSH, 16'($urandom), pick_priority());
      send_op(spq_pkg::OP_PUSH, 16'hFFFF, 16'hFFFF);
      send_op(spq_pkg::OP_POP, '0, '0);
   endtask

   // Bursts leaning to pushes or pops so the queue swings between full and empty
   task automatic run_mix(int unsigned items);
      int unsigned done;
      int unsigned push_pct;
      int unsigned burst;
      done = 0;
      while (done < items) begin
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         burst = $urandom_range(40, 4);
         repeat (burst) begin
            if ($urandom_range(99) < push_pct)
               send_op(spq_pkg::OP_PUSH, 16'($urandom), pick_priority());
            else
               send_op(spq_pkg::OP_POP, 16'($urandom), 16'($urandom));
            done++;
         end
      end
   endtask

   task automatic test_slow_receiver();
      send_idle_pct = 6;
      recv_idle_pct = 50;
      run_mix(500);
   endtask

   task automatic test_slow_sender();
      send_idle_pct = 50;
      recv_idle_pct = 6;
      run_mix(500);
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_mix(480);
   endtask

   // Hold the response side off for a long stretch while requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_kick <= ~hold_kick;
      run_mix(40);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_pop();
      test_order_and_ties();
      test_full_queue();
      test_slow_receiver();
      test_slow_sender();
      test_full_rate();
      test_backpressure();

      // Drop valid, wait for the outstanding responses, then let the pipe settle
      req_tvalid <= 1'b0;
      drain_wait = 0;
      while (pending_responses.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      if (pending_responses.size() != 0) begin
         mismatches += pending_responses.size();
         $display("%0d expected responses never arrived", pending_responses.size());
      end
      repeat (10) @(posedge clock);

      $display("Ran %0d pushes (%0d dropped on a full queue) and %0d pops (%0d on empty).",
               push_count, full_drops, pop_count, empty_pops);
      $display("Checked %0d responses, peak occupancy %0d of %0d, %0d mismatching fields.",
               responses, peak_count, DEPTH, mismatches);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
